// ===== sv/pss_pkg.sv =====
// Shared types and constants for the positional sequence store.
package pss_pkg;

  localparam int DEPTH = 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int POS_W = 6;
  localparam int VAL_W = 32;
  localparam int LEN_W = 6;
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_DUMP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_BAD_POS = 2'd1,
    STS_FULL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_ROT
  } cell_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } pss_state_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    cell_op_t                op;
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] value;
  } cell_ctl_t;

  typedef struct packed {
    cmd_t                    cmd;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    status_t                 status;
    logic                    has_value;
    logic signed [VAL_W-1:0] elem_value;
    logic                    last;
    logic [LEN_W-1:0]        length;
  } out_item_t;

endpackage

// ===== sv/pss_cell.sv =====
// One storage cell of the shifting element chain.
module pss_cell
  import pss_pkg::*;
(
  input  logic                    clk,
  input  logic [IDX_W-1:0]        cell_idx,
  input  cell_ctl_t               ctl,
  input  logic signed [VAL_W-1:0] left_val,
  input  logic signed [VAL_W-1:0] right_val,
  input  logic signed [VAL_W-1:0] head_val,
  output logic signed [VAL_W-1:0] val
);

  logic signed [VAL_W-1:0] val_r;
  logic signed [VAL_W-1:0] val_nxt;

  // Pick the next value from self, neighbors, head or the broadcast value
  always_comb begin
    val_nxt = val_r;
    case (ctl.op)
      CELL_INS: begin
        if (cell_idx == ctl.idx) begin
          val_nxt = ctl.value;
        end else if (cell_idx > ctl.idx) begin
          val_nxt = left_val;
        end
      end
      CELL_DEL: begin
        if (cell_idx >= ctl.idx) begin
          val_nxt = right_val;
        end
      end
      CELL_ROT: begin
        if (cell_idx < ctl.idx) begin
          val_nxt = right_val;
        end else if (cell_idx == ctl.idx) begin
          val_nxt = head_val;
        end
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

// ===== sv/positional_sequence_store.sv =====
// Positional sequence store: a chain of value cells under one sequencer.
// Append, insert and delete: one result, registered in the cycle after acceptance.
// Dump: one result per stored element, one per cycle while out_stall is low;
// the chain rotates the live cells by one per emitted element and in_stall stays high.
// Throughput: one command per cycle while out_stall is low; a dump holds the input until its last element is emitted.
// Reset clears count, sequencer state and output valid; cell contents are not reset.
module positional_sequence_store
  import pss_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  pss_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] dump_cnt_r, dump_cnt_nxt;
  logic             out_valid_r;
  out_item_t        out_data_r;
  out_item_t        out_nxt;
  logic             out_load;
  logic             slot_free;
  logic             in_fire;
  logic             pos_bad;
  logic             full;
  logic [IDX_W-1:0] pos_idx;
  cell_ctl_t        ctl;
  logic signed [VAL_W-1:0] cell_val [DEPTH];

  // Build the cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_v;
    logic signed [VAL_W-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = ctl.value;
    end else begin : g_mid_l
      assign left_v = cell_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_lastc
      assign right_v = cell_val[i];
    end else begin : g_mid_r
      assign right_v = cell_val[i+1];
    end
    pss_cell u_cell (
      .clk       (clk),
      .cell_idx  (IDX_W'(i)),
      .ctl       (ctl),
      .left_val  (left_v),
      .right_val (right_v),
      .head_val  (cell_val[0]),
      .val       (cell_val[i])
    );
  end

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == ST_IDLE) && slot_free);
  assign in_fire   = in_valid && !in_stall;
  assign pos_bad   = (CMP_W'(in_data.position) == CMP_W'(0)) ||
                     (CMP_W'(in_data.position) > CMP_W'(count_r));
  assign full      = (count_r == CNT_W'(DEPTH));
  assign pos_idx   = IDX_W'(in_data.position - POS_W'(1));

  // Sequencer: next state, cell control and result item
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    dump_cnt_nxt = dump_cnt_r;
    out_load     = 1'b0;
    out_nxt      = '0;
    ctl.op       = CELL_HOLD;
    ctl.idx      = '0;
    ctl.value    = in_data.value;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          out_load     = 1'b1;
          out_nxt.last = 1'b1;
          case (in_data.cmd)
            CMD_APPEND: begin
              if (full) begin
                out_nxt.status = STS_FULL;
              end else begin
                ctl.op    = CELL_INS;
                ctl.idx   = IDX_W'(count_r);
                count_nxt = count_r + CNT_W'(1);
              end
            end
            CMD_INSERT: begin
              if (pos_bad) begin
                out_nxt.status = STS_BAD_POS;
              end else if (full) begin
                out_nxt.status = STS_FULL;
              end else begin
                ctl.op    = CELL_INS;
                ctl.idx   = pos_idx;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            CMD_DELETE: begin
              if (pos_bad) begin
                out_nxt.status = STS_BAD_POS;
              end else begin
                ctl.op    = CELL_DEL;
                ctl.idx   = pos_idx;
                count_nxt = count_r - CNT_W'(1);
              end
            end
            CMD_DUMP: begin
              // empty store answers with a single bare item
              if (count_r != '0) begin
                out_load     = 1'b0;
                state_nxt    = ST_DUMP;
                dump_cnt_nxt = '0;
              end
            end
            default: out_load = 1'b0;
          endcase
          out_nxt.length = LEN_W'(count_nxt);
        end
      end
      ST_DUMP: begin
        // emit the head cell and rotate the live cells by one
        if (slot_free) begin
          out_load           = 1'b1;
          out_nxt.has_value  = 1'b1;
          out_nxt.elem_value = cell_val[0];
          out_nxt.last       = (dump_cnt_r == count_r - CNT_W'(1));
          out_nxt.length     = LEN_W'(count_r);
          ctl.op             = CELL_ROT;
          ctl.idx            = IDX_W'(count_r - CNT_W'(1));
          dump_cnt_nxt       = dump_cnt_r + CNT_W'(1);
          if (out_nxt.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      count_r    <= '0;
      dump_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      dump_cnt_r <= dump_cnt_nxt;
    end
  end

  // Hold the result item until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("element count above depth");

  a_dump_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DUMP) |-> in_stall)
    else $error("input taken during dump");

  a_cmd_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_data.cmd != CMD_DUMP)) |=> (out_valid_r && out_data_r.last))
    else $error("command gave no final result");

  a_delete_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_data.cmd == CMD_DELETE) && !pos_bad)
      |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("delete did not shrink the store");

endmodule
